### rtl/pts_pkg.sv
// pts_pkg: shared types and constants for the periodic task scheduler.
// No dependencies.
`default_nettype none
package pts_pkg;
	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_RESCHED = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	localparam logic [2:0] KIND_PLACED = 3'd0;
	localparam logic [2:0] KIND_FULL = 3'd1;
	localparam logic [2:0] KIND_FOUND = 3'd2;
	localparam logic [2:0] KIND_MISSING = 3'd3;
	localparam logic [2:0] KIND_RESCHED = 3'd4;
	localparam logic [2:0] KIND_IGNORED = 3'd5;
	localparam logic [2:0] KIND_DUE = 3'd6;
	localparam logic [2:0] KIND_SLEEP = 3'd7;

	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] period;
		logic [31:0] last_run;
	} pts_entry_t;

	// per-cell command, same for all cells in a cycle
	typedef struct packed {
		logic        ins;      // insert shift
		logic        resched;  // write last_run of addressed cell
		logic        touch;    // tick: mark this cycle's scanned cell as run
		logic [SLOT_W-1:0] sel;
		logic [31:0] rate;
		logic [31:0] value;    // new last_run for insert / resched / tick
		logic [15:0] tag;
	} pts_cmd_t;
endpackage
`default_nettype wire

### rtl/pts_cell.sv
// pts_cell: one table slot; shifts up on insert when its period exceeds the rate.
// Depends on pts_pkg.
`default_nettype none
module pts_cell (
	input  wire logic              clk,
	input  wire logic [pts_pkg::SLOT_W-1:0] idx,
	input  wire logic              occ,      // slot currently occupied
	input  wire logic              prev_shift,
	input  wire pts_pkg::pts_entry_t prev_entry,
	input  wire pts_pkg::pts_cmd_t cmd,
	output pts_pkg::pts_entry_t    entry,
	output logic                   shift     // this cell moves up on insert
);
	import pts_pkg::*;
	pts_entry_t entry_q;
	logic place;

	assign entry = entry_q;
	assign shift = occ && (entry_q.period > cmd.rate);
	// new entry lands in first free or first shifting slot
	assign place = (shift || !occ) && !prev_shift;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_shift && (shift || !occ))
				entry_q <= prev_entry;
			else if (place) begin
				entry_q.tag <= cmd.tag;
				entry_q.period <= cmd.rate;
				entry_q.last_run <= cmd.value;
			end
		end else if ((cmd.resched || cmd.touch) && cmd.sel == idx) begin
			entry_q.last_run <= cmd.value;
		end
	end
endmodule
`default_nettype wire

### rtl/periodic_task_scheduler.sv
// periodic_task_scheduler: top level, sequencer over a row of pts_cell slots.
// Depends on pts_pkg and pts_cell.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  in       | in_valid/in_stall| operation task_tag rate run_now slot_number
//           |                  | when_ms now_ms
//  out      | out_valid/out_st.| kind slot sleep_time final_item
//  cfg      | cfg_we           | cfg_wdata (sleep_slack)
//
// Add, lookup, reschedule: result valid the cycle after the beat is taken; with
// no output stall the next input can be taken on the following edge.
// Tick: two passes over the slots, one slot per cycle each (due pass, then
// sleep pass); a due slot is held while the output is full and stalled, and
// each pass ends in a turn-around step.
// A single output register holds each beat; the sequencer waits while it is full
// and stalled. A new input is taken only when the sequencer is idle.
// Reset clears entry count, slack (to 1) and control; slot contents are
// undefined until written.
`default_nettype none
module periodic_task_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] task_tag,
	input  wire logic [31:0] rate,
	input  wire logic        run_now,
	input  wire logic [7:0]  slot_number,
	input  wire logic [31:0] when_ms,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [3:0]       slot,
	output logic [31:0]      sleep_time,
	output logic             final_item,
	input  wire logic        cfg_we,
	input  wire logic [9:0]  cfg_wdata
);
	import pts_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DUE = 2'd1;
	localparam logic [1:0] ST_SLP = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [9:0] slack_q;
	logic [31:0] now_q;
	logic [31:0] sleep_q;

	pts_entry_t ent [TASK_SLOTS];
	logic shf [TASK_SLOTS];
	pts_cmd_t cmd;

	logic out_free, accept, emit;
	logic [2:0] e_kind;
	logic [SLOT_W-1:0] e_slot;
	logic [31:0] e_sleep;
	logic e_fin;

	// lookup: highest occupied match
	logic hit;
	logic [SLOT_W-1:0] hit_idx;
	pts_entry_t cur;
	logic [31:0] d, to;
	logic due;

	genvar g;
	generate
		for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
			pts_cell u_cell (
				.clk(clk),
				.idx(SLOT_W'(g)),
				.occ(CNT_W'(g) < count_q),
				.prev_shift(g == 0 ? 1'b0 : shf[(g == 0) ? 0 : g-1]),
				.prev_entry(ent[(g == 0) ? 0 : g-1]),
				.cmd(cmd),
				.entry(ent[g]),
				.shift(shf[g])
			);
		end
	endgenerate

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept = in_valid && !in_stall;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < TASK_SLOTS; i++)
			if (CNT_W'(i) < count_q && ent[i].tag == task_tag) begin
				hit = 1'b1;
				hit_idx = SLOT_W'(i);
			end
	end

	assign cur = ent[scan_q[SLOT_W-1:0]];
	assign d = now_q - cur.last_run;
	assign due = d >= cur.period;
	assign to = (d < cur.period) ? (cur.period - d) : cur.period;

	always_comb begin
		cmd = '0;
		cmd.rate = rate;
		cmd.tag = task_tag;
		emit = 1'b0;
		e_kind = KIND_SLEEP;
		e_slot = '0;
		e_sleep = '0;
		e_fin = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emit = (operation != OP_TICK);
					case (operation)
						OP_ADD: begin
							if (count_q >= CNT_W'(TASK_SLOTS)) e_kind = KIND_FULL;
							else begin
								cmd.ins = 1'b1;
								cmd.value = run_now ? (32'd0 - rate) : 32'd0;
								e_kind = KIND_PLACED;
								e_slot = SLOT_W'(count_q);
								for (int i = TASK_SLOTS - 1; i >= 0; i--)
									if (shf[i]) e_slot = SLOT_W'(i);
							end
						end
						OP_LOOKUP: begin
							e_kind = hit ? KIND_FOUND : KIND_MISSING;
							e_slot = hit ? hit_idx : '0;
						end
						OP_RESCHED: begin
							if ({1'b0, slot_number} >= 9'(TASK_SLOTS) ||
							    {1'b0, slot_number} >= 9'(count_q))
								e_kind = KIND_IGNORED;
							else begin
								e_kind = KIND_RESCHED;
								cmd.resched = 1'b1;
								cmd.sel = slot_number[SLOT_W-1:0];
								cmd.value = ((when_ms < ent[cmd.sel].period) ?
									ent[cmd.sel].period : when_ms) - ent[cmd.sel].period;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DUE: begin
				// only occupied slots are tested
				if (out_free && due && scan_q < count_q) begin
					emit = 1'b1;
					e_kind = KIND_DUE;
					e_slot = scan_q[SLOT_W-1:0];
					e_fin = 1'b0;
					cmd.touch = 1'b1;
					cmd.sel = scan_q[SLOT_W-1:0];
					cmd.value = now_q;
				end
			end
			ST_SLP: begin
				if (out_free && scan_q >= count_q) begin
					emit = 1'b1;
					e_sleep = sleep_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q <= '0;
			slack_q <= 10'd1;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) slack_q <= cfg_wdata;
			if (out_free) out_valid <= emit;
			if (cmd.ins) count_q <= count_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (accept && operation == OP_TICK) begin
						state_q <= ST_DUE;
						scan_q <= '0;
					end
				end
				ST_DUE: begin
					if (scan_q >= count_q) begin
						state_q <= ST_SLP;
						scan_q <= '0;
					end else if (out_free || !due) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_SLP: begin
					if (scan_q >= count_q) begin
						if (out_free) state_q <= ST_IDLE;
					end else
						scan_q <= scan_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && operation == OP_TICK) begin
			now_q <= now_ms;
			sleep_q <= 32'hFFFF_FFFF;
		end else if (state_q == ST_SLP && scan_q < count_q) begin
			if (to < (sleep_q - 32'(slack_q))) sleep_q <= to;
		end
		if (out_free && emit) begin
			kind <= e_kind;
			slot <= 4'(e_slot);
			sleep_time <= e_sleep;
			final_item <= e_fin;
		end
	end
endmodule
`default_nettype wire

### rtl/pts_checker.sv
// pts_checker: port-level assertions for periodic_task_scheduler, bound to top.
// Depends on pts_pkg.
`default_nettype none
module pts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  kind,
	input wire logic [3:0]  slot,
	input wire logic [31:0] sleep_time,
	input wire logic        final_item
);
	import pts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(sleep_time))
		else $error("stalled result changed");
	a_sleep_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SLEEP |-> final_item && slot == 4'd0)
		else $error("sleep beat not final");
	a_due_notfinal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DUE |-> !final_item && sleep_time == 32'd0)
		else $error("due beat marked final");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken with full output");
endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind), .slot(slot),
	.sleep_time(sleep_time), .final_item(final_item)
);
`default_nettype wire
